### rtl/modular_exponentiation_macros.svh
// ----------------------------------------------------------------------------
// modular exponentiation assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ME_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/me_pkg.sv
// ----------------------------------------------------------------------------
// me_pkg
// shared constants for the modular exponentiation block
// ----------------------------------------------------------------------------
package me_pkg;

    // default datapath width, operands are one bit narrower
    localparam int DATA_WIDTH_DEF = 64;

    // modulus value after reset
    localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

endpackage

### rtl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// modular_exponentiation
// base to the power exponent modulo a configured modulus, right-to-left
// square-and-multiply over one shared bit-serial modular multiplier
// ----------------------------------------------------------------------------
// channel    direction  handshake                 payload
// command    in         start high, busy low      i_base_value, i_exponent
// result     out        o_done strobe, 1 cycle    o_power_result
// config     in         i_cfg_valid, o_cfg_ready  i_cfg_data (modulus)
//
// each modular product runs through the bit-serial multiplier, one multiplier
// bit per cycle; an exponent with n significant bits and k set bits needs a
// reduction of the base, k multiplies and n - 1 squarings before the strobe
// a zero exponent or a modulus of at most one strobes in the cycle after accept
// reset is synchronous and active low and reloads the modulus to 1000000007
// the result strobe cannot be held off; busy stays high until it has shown
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int DATA_WIDTH = me_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DATA_WIDTH-2:0] i_base_value,
    input  logic [DATA_WIDTH-2:0] i_exponent,
    output logic                  o_done,
    output logic [DATA_WIDTH-2:0] o_power_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [DATA_WIDTH-2:0] i_cfg_data
);
    import me_pkg::*;

    localparam int W = DATA_WIDTH - 1;
    localparam logic [W-1:0] MOD_RST = MODULUS_RESET[W-1:0];
    localparam logic [W-1:0] ONE     = {{(W-1){1'b0}}, 1'b1};

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_BIT  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SQR  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]   r_state;
    logic [W-1:0] r_mod;
    logic [W-1:0] r_base;
    logic [W-1:0] r_exp;
    logic [W-1:0] r_res;

    logic [2:0]   n_state;
    logic [W-1:0] n_base;
    logic [W-1:0] n_exp;
    logic [W-1:0] n_res;

    logic         mm_start;
    logic [W-1:0] mm_a;
    logic [W-1:0] mm_b;
    logic         mm_done;
    logic [W-1:0] mm_product;
    logic         exp_last;

    // shared modular multiplier
    me_mulmod #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mm_start),
        .i_a       (mm_a),
        .i_b       (mm_b),
        .i_m       (r_mod),
        .o_done    (mm_done),
        .o_product (mm_product)
    );

    assign exp_last = (r_exp[W-1:1] == '0);

    // sequencer: reduce the base, then per exponent bit multiply if it is set and square unless it is the last
    always_comb begin
        n_state  = r_state;
        n_base   = r_base;
        n_exp    = r_exp;
        n_res    = r_res;
        mm_start = 1'b0;
        mm_a     = r_res;
        mm_b     = r_base;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_exp = i_exponent;
                    if (i_exponent == '0) begin
                        n_res   = ONE;
                        n_state = S_OUT;
                    end else if (r_mod <= ONE) begin
                        n_res   = '0;
                        n_state = S_OUT;
                    end else begin
                        // base mod m as 1 * base through the multiplier
                        mm_start = 1'b1;
                        mm_a     = ONE;
                        mm_b     = i_base_value;
                        n_state  = S_RED;
                    end
                end
            end
            S_RED: begin
                if (mm_done) begin
                    n_base  = mm_product;
                    n_res   = ONE;
                    n_state = S_BIT;
                end
            end
            S_BIT: begin
                mm_start = 1'b1;
                if (r_exp[0]) begin
                    n_state = S_MUL;
                end else begin
                    mm_a    = r_base;
                    n_state = S_SQR;
                end
            end
            S_MUL: begin
                if (mm_done) begin
                    n_res = mm_product;
                    if (exp_last) begin
                        n_state = S_OUT;
                    end else begin
                        mm_start = 1'b1;
                        mm_a     = r_base;
                        n_state  = S_SQR;
                    end
                end
            end
            S_SQR: begin
                if (mm_done) begin
                    n_base  = mm_product;
                    n_exp   = {1'b0, r_exp[W-1:1]};
                    n_state = S_BIT;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mod   <= MOD_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_mod <= i_cfg_data;
            end
        end
    end

    // working operands
    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_exp  <= n_exp;
        r_res  <= n_res;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = (r_state == S_OUT);
    assign o_power_result = r_res;
    assign o_cfg_ready    = 1'b1;

endmodule

### rtl/me_mulmod.sv
// ----------------------------------------------------------------------------
// me_mulmod
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
// ----------------------------------------------------------------------------
module me_mulmod #(
    parameter int DATA_WIDTH = me_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DATA_WIDTH-2:0] i_a,
    input  logic [DATA_WIDTH-2:0] i_b,
    input  logic [DATA_WIDTH-2:0] i_m,
    output logic                  o_done,
    output logic [DATA_WIDTH-2:0] o_product
);
    localparam int W  = DATA_WIDTH - 1;
    localparam int CW = $clog2(W);
    localparam int TW = W + 2;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_acc;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;

    logic [TW-1:0] sum;
    logic [TW-1:0] m1;
    logic [TW-1:0] m2;
    logic [W-1:0]  n_acc;

    // double, add the multiplicand when the bit is set, fold back below m
    // (acc and a stay below m, so the sum stays below 3m)
    always_comb begin
        m1  = {2'b00, i_m};
        m2  = {1'b0, i_m, 1'b0};
        sum = {1'b0, r_acc, 1'b0} + (r_b[W-1] ? {2'b00, r_a} : '0);
        if (sum >= m2) begin
            n_acc = W'(sum - m2);
        end else if (sum >= m1) begin
            n_acc = W'(sum - m1);
        end else begin
            n_acc = sum[W-1:0];
        end
    end

    // step counter and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // operand and accumulator registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[W-2:0], 1'b0};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

### rtl/me_checker.sv
// ----------------------------------------------------------------------------
// me_checker
// port-level checks on the command and result timing of the top level
// ----------------------------------------------------------------------------
`include "modular_exponentiation_macros.svh"

module me_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done
);

    // a result only shows while a transaction is in flight
    `ME_ASSERT_NOW(a_done_busy, i_clk, i_rst_n, o_done, busy, "result strobe while idle")

    // an accepted command makes the block busy
    `ME_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "accept without busy")

    // the result strobe lasts one cycle
    `ME_ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done, "result strobe held")

    // the block is free again right after the result
    `ME_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done, !busy, "busy after result")

endmodule

bind modular_exponentiation me_checker u_me_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for modular_exponentiation: a double-width predictor of
// base^exponent mod modulus scores every result strobe, under directed corner
// items and random phases with varied moduli and random start gaps
// ----------------------------------------------------------------------------
module tb;

    localparam int W = me_pkg::DATA_WIDTH_DEF - 1;
    localparam logic [W-1:0] OPERAND_MAX = {W{1'b1}};
    localparam int RANDOM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 150;

    typedef struct {
        logic [W-1:0] base;
        logic [W-1:0] expo;
        logic [W-1:0] power;
    } t_power_expect;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    logic [W-1:0]   i_base_value;
    logic [W-1:0]   i_exponent;
    logic           o_done;
    logic [W-1:0]   o_power_result;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [W-1:0]   i_cfg_data;

    t_power_expect  pending_powers[$];
    logic [W-1:0]   modulus_model = me_pkg::MODULUS_RESET[W-1:0];
    int             mismatch_count = 0;
    int             item_count = 0;
    int             result_count = 0;
    int             cfg_count = 0;

    modular_exponentiation DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_base_value   (i_base_value),
        .i_exponent     (i_exponent),
        .o_done         (o_done),
        .o_power_result (o_power_result),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // clock, 2 ns period
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // (a * b) mod m with the product kept at full double width
    function automatic logic [W-1:0] mult_reduce(input logic [W-1:0] a,
                                                 input logic [W-1:0] b,
                                                 input logic [W-1:0] m);
        logic [2*W-1:0] wa;
        logic [2*W-1:0] wb;
        logic [2*W-1:0] wm;
        logic [2*W-1:0] prod;
        wa = {{W{1'b0}}, a};
        wb = {{W{1'b0}}, b};
        wm = {{W{1'b0}}, m};
        prod = wa * wb;
        prod = prod % wm;
        return prod[W-1:0];
    endfunction

    // right-to-left square-and-multiply
    function automatic logic [W-1:0] power_mod(input logic [W-1:0] base,
                                               input logic [W-1:0] expo,
                                               input logic [W-1:0] m);
        logic [W-1:0] acc;
        logic [W-1:0] sq;
        if (expo == '0)
            return W'(1);
        if (m <= W'(1))
            return '0;
        acc = W'(1);
        sq = base % m;
        for (int i = 0; i < W; i++) begin
            if (expo[i])
                acc = mult_reduce(acc, sq, m);
            sq = mult_reduce(sq, sq, m);
        end
        return acc;
    endfunction

    function automatic logic [W-1:0] rand_operand();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[W-1:0];
    endfunction

    // mostly short exponents to bound run time, a few at full width
    function automatic logic [W-1:0] pick_exponent();
        int unsigned sel;
        int unsigned nbits;
        logic [W-1:0] mask;
        sel = $urandom_range(0, 99);
        if (sel < 2)
            return rand_operand();
        nbits = (sel < 8) ? $urandom_range(6, 12) : $urandom_range(0, 5);
        mask = (W'(1) << nbits) - W'(1);
        return rand_operand() & mask;
    endfunction

    function automatic logic [W-1:0] pick_base();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return OPERAND_MAX;
            2: return modulus_model;
            3: return modulus_model - W'(1);
            4, 5: return W'($urandom_range(0, 1000));
            default: return rand_operand();
        endcase
    endfunction

    function automatic logic [W-1:0] pick_modulus();
        case ($urandom_range(0, 7))
            0: return rand_operand();
            1: return W'($urandom_range(2, 1000));
            2: return W'($urandom);
            3: return OPERAND_MAX;
            4: return W'(1);
            5: return W'(1) << $urandom_range(1, W - 1);
            6: return me_pkg::MODULUS_RESET[W-1:0];
            default: return rand_operand() | (W'(1) << (W - 1));
        endcase
    endfunction

    // one command transaction; start is left high for a back-to-back follow-up
    task automatic send_power_request(input logic [W-1:0] base,
                                      input logic [W-1:0] expo);
        int unsigned gap;
        t_power_expect entry;
        gap = $urandom_range(0, 7);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_base_value <= base;
        i_exponent   <= expo;
        start        <= 1'b1;
        do @(posedge i_clk); while (busy);
        entry = '{base, expo, power_mod(base, expo, modulus_model)};
        pending_powers.insert(pending_powers.size(), entry);
        item_count++;
    endtask

    // drop start and let every outstanding result come back
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_powers.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // one config transaction, only while the block is idle
    task automatic write_modulus(input logic [W-1:0] value);
        wait_idle();
        repeat ($urandom_range(0, 7)) @(posedge i_clk);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        modulus_model = value;
        i_cfg_valid <= 1'b0;
        cfg_count++;
    endtask

    // corners under the modulus loaded by reset
    task automatic test_reset_modulus();
        send_power_request('0, '0);
        send_power_request(W'(2), W'(10));
        send_power_request(OPERAND_MAX, W'(1));
        send_power_request('0, W'(5));
        send_power_request(me_pkg::MODULUS_RESET[W-1:0], W'(3));
        send_power_request(me_pkg::MODULUS_RESET[W-1:0] - W'(1), W'(2));
        send_power_request(OPERAND_MAX, OPERAND_MAX);
    endtask

    // largest modulus, modulus of one and zero, tiny and power-of-two moduli
    task automatic test_modulus_extremes();
        write_modulus(OPERAND_MAX);
        send_power_request(OPERAND_MAX - W'(1), W'(2));
        send_power_request(OPERAND_MAX, W'(1));
        send_power_request(OPERAND_MAX - W'(2), OPERAND_MAX);
        send_power_request(W'(12345), '0);
        write_modulus(W'(1));
        send_power_request(W'(5), '0);
        send_power_request(W'(5), W'(7));
        send_power_request('0, W'(1));
        write_modulus('0);
        send_power_request(W'(7), '0);
        send_power_request(W'(7), W'(3));
        write_modulus(W'(2));
        send_power_request(W'(3), OPERAND_MAX);
        send_power_request(W'(4), W'(1));
        write_modulus(W'(1) << (W - 1));
        send_power_request(W'(3), W'(62));
        send_power_request(OPERAND_MAX, W'({W/2{2'b01}}));
    endtask

    // random phases, each under a freshly written modulus
    task automatic test_random_traffic();
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_modulus(pick_modulus());
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_power_request(pick_base(), pick_exponent());
        end
    endtask

    // result checker, compares each strobe with the oldest expectation
    always @(posedge i_clk) begin
        t_power_expect exp_item;
        if (i_rst_n && o_done) begin
            if (pending_powers.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, o_power_result);
                mismatch_count++;
            end else begin
                exp_item = pending_powers.pop_front();
                result_count++;
                if (o_power_result !== exp_item.power) begin
                    $display("%0t: power mismatch base=%h exp=%h expected %h actual %h",
                             $time, exp_item.base, exp_item.expo, exp_item.power,
                             o_power_result);
                    mismatch_count++;
                end
            end
        end
    end

    // main sequence
    initial begin
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_base_value <= '0;
        i_exponent   <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_data   <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_modulus();
        test_modulus_extremes();
        test_random_traffic();

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (pending_powers.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_powers.size());
            mismatch_count++;
        end
        $display("run covered %0d exponentiations and %0d modulus writes, %0d results checked",
                 item_count, cfg_count, result_count);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/me_pkg.sv
rtl/me_mulmod.sv
rtl/modular_exponentiation.sv
rtl/me_checker.sv
tb/tb.sv
